// File: hw/rtl/multiclass_hysteresis_alarm_defines.svh
// Assertion macros shared by the hysteresis alarm RTL.
// Included by every module that carries concurrent assertions.
`ifndef MULTICLASS_HYSTERESIS_ALARM_DEFINES_SVH
`define MULTICLASS_HYSTERESIS_ALARM_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MHA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hysteresis alarm: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hysteresis alarm: next-cycle check failed");

`endif

// File: hw/rtl/mha_pkg.sv
// Types and constants for the multiclass hysteresis alarm.
// No dependencies; imported by every module of the block.
package mha_pkg;

    localparam int unsigned NUM_THR_REGS = 4;
    localparam int unsigned MASK_W       = 4;
    localparam int unsigned PROB_W       = 16;
    localparam int unsigned NEED_W       = 10;
    localparam int unsigned OUT_CNT_W    = 10;
    localparam int unsigned CFG_IDX_W    = 3;
    localparam int unsigned CFG_DATA_W   = 32;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_THR0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THR1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THR2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THR3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NEED = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MASK = 3'd5;

    localparam logic [CFG_DATA_W-1:0] THR_RESET  = 32'hB333_8000;
    localparam logic [NEED_W-1:0]     NEED_RESET = 10'd3;
    localparam logic [MASK_W-1:0]     MASK_RESET = 4'd0;

    typedef struct packed {
        logic              opcode;
        logic [1:0]        class_index;
        logic [PROB_W-1:0] probability;
    } t_in_item;

    typedef struct packed {
        logic                 class_active;
        logic [OUT_CNT_W-1:0] class_count;
        logic [MASK_W-1:0]    active_mask;
        logic                 any_alert;
    } t_out_item;

    typedef struct packed {
        logic [NUM_THR_REGS-1:0][CFG_DATA_W-1:0] thr;
        logic [NEED_W-1:0]                       need_count;
        logic [MASK_W-1:0]                       other_mask;
    } t_cfg;

endpackage

// File: hw/rtl/multiclass_hysteresis_alarm.sv
// Top level of the multiclass hysteresis alarm.
// Depends on mha_pkg, mha_cfg_regs, mha_class_update and mha_out_skid.
//
// Usage: each request on the input channel carries an opcode, a class index and
// a Q0.16 probability. A request is taken at a clock edge where i_in_valid is
// high and o_in_stall is low. A sample request updates the hit count and active
// flag of its class; a clear request zeroes every class. Exactly one result per
// request leaves on the output channel, taken where o_out_valid is high and
// i_out_stall is low.
// A request's result is registered in the output register, or in the skid
// register under a stall. Throughput is one request per cycle while o_in_stall
// is low, set by the single state update at acceptance. When the receiver
// stalls, the output register holds its result and one more result parks in the
// skid register; the input stalls only while that skid register is occupied.
// Configuration writes use i_cfg_valid and o_cfg_ready, which is always high,
// and are to be issued only while no result is pending.
// Reset is synchronous and active low: thresholds return to on 0xB333 and off
// 0x8000, the need count to three, the alert mask to zero, every count and flag
// to zero, and both output registers empty.
module multiclass_hysteresis_alarm
    import mha_pkg::*;
#(
    parameter int unsigned NUM_CLASSES = 4,
    parameter int unsigned COUNT_CAP   = 1000
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      w_cfg;
    t_out_item w_result;
    logic      w_accept;
    logic      w_full;

    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid && !w_full;

    mha_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    mha_class_update #(
        .NUM_CLASSES (NUM_CLASSES),
        .COUNT_CAP   (COUNT_CAP)
    ) u_class_update (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_in_data),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    mha_out_skid u_out_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_accept),
        .i_result    (w_result),
        .o_full      (w_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// File: hw/rtl/mha_cfg_regs.sv
// Configuration register file of the hysteresis alarm.
// Depends on mha_pkg for register indexes, reset values and t_cfg.
module mha_cfg_regs
    import mha_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_THR_REGS; i++) begin
                r_cfg.thr[i] <= THR_RESET;
            end
            r_cfg.need_count <= NEED_RESET;
            r_cfg.other_mask <= MASK_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index) inside
                REG_THR0, REG_THR1, REG_THR2, REG_THR3: begin
                    r_cfg.thr[i_cfg_index[1:0]] <= i_cfg_data;
                end
                REG_NEED: begin
                    r_cfg.need_count <= i_cfg_data[NEED_W-1:0];
                end
                REG_MASK: begin
                    r_cfg.other_mask <= i_cfg_data[MASK_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/mha_class_update.sv
// Per-class hit counters and active flags with the hysteresis update.
// Depends on mha_pkg; produces one result for every accepted request.
module mha_class_update
    import mha_pkg::*;
#(
    parameter int unsigned NUM_CLASSES = 4,
    parameter int unsigned COUNT_CAP   = 1000
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    localparam int unsigned CNT_W = $clog2(COUNT_CAP + 1);
    localparam int unsigned CMP_W = (CNT_W > NEED_W) ? CNT_W : NEED_W;
    localparam logic [2:0]  NUM_CLASSES_V = 3'(NUM_CLASSES);
    localparam logic [CNT_W-1:0] CAP_V = CNT_W'(COUNT_CAP);

    logic [CNT_W-1:0] r_cnt [NUM_CLASSES];
    logic             r_act [NUM_CLASSES];
    logic [CNT_W-1:0] n_cnt [NUM_CLASSES];
    logic             n_act [NUM_CLASSES];

    logic [PROB_W-1:0] w_on_thr;
    logic [PROB_W-1:0] w_off_thr;
    logic              w_idx_ok;
    logic              w_is_clear;
    logic              w_above_on;
    logic              w_below_off;
    logic [MASK_W-1:0] w_mask;
    logic              w_sel_act;
    logic [CNT_W-1:0]  w_sel_cnt;

    assign w_on_thr    = i_cfg.thr[i_item.class_index][31:16];
    assign w_off_thr   = i_cfg.thr[i_item.class_index][15:0];
    assign w_idx_ok    = {1'b0, i_item.class_index} < NUM_CLASSES_V;
    assign w_is_clear  = (i_item.opcode == OP_CLEAR);
    assign w_above_on  = i_item.probability > w_on_thr;
    assign w_below_off = i_item.probability < w_off_thr;

    for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_class
        logic [CNT_W-1:0] w_inc;
        logic             w_hit_c;

        assign w_hit_c = (i_item.class_index == 2'(c));
        assign w_inc   = (r_cnt[c] < CAP_V) ? r_cnt[c] + CNT_W'(1) : r_cnt[c];

        always_comb begin
            n_cnt[c] = r_cnt[c];
            n_act[c] = r_act[c];
            if (w_is_clear) begin
                n_cnt[c] = '0;
                n_act[c] = 1'b0;
            end else if (w_hit_c) begin
                if (w_above_on) begin
                    n_cnt[c] = w_inc;
                    if (CMP_W'(w_inc) >= CMP_W'(i_cfg.need_count)) begin
                        n_act[c] = 1'b1;
                    end
                end else if (w_below_off) begin
                    n_cnt[c] = '0;
                    n_act[c] = 1'b0;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cnt[c] <= '0;
                r_act[c] <= 1'b0;
            end else if (i_accept) begin
                r_cnt[c] <= n_cnt[c];
                r_act[c] <= n_act[c];
            end
        end
    end

    for (genvar m = 0; m < MASK_W; m++) begin : g_mask
        if (m < NUM_CLASSES) begin : g_used
            assign w_mask[m] = n_act[m];
        end else begin : g_unused
            assign w_mask[m] = 1'b0;
        end
    end

    always_comb begin
        w_sel_act = 1'b0;
        w_sel_cnt = '0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            if (i_item.class_index == 2'(c)) begin
                w_sel_act = n_act[c];
                w_sel_cnt = n_cnt[c];
            end
        end
    end

    always_comb begin
        o_result.class_active = w_idx_ok && !w_is_clear && w_sel_act;
        o_result.class_count  = (w_idx_ok && !w_is_clear)
                              ? OUT_CNT_W'(w_sel_cnt) : '0;
        o_result.active_mask  = w_mask;
        o_result.any_alert    = |(w_mask & ~i_cfg.other_mask);
    end

endmodule

// File: hw/rtl/mha_out_skid.sv
// Output register with a skid stage for the result channel.
// Depends on mha_pkg for t_out_item and on the shared assertion macros.
`include "multiclass_hysteresis_alarm_defines.svh"

module mha_out_skid
    import mha_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_item i_result,
    output logic      o_full,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic      r_main_valid;
    logic      r_skid_valid;
    t_out_item r_main;
    t_out_item r_skid;
    logic      w_take;

    assign w_take      = r_main_valid && !i_out_stall;
    assign o_full      = r_skid_valid;
    assign o_out_valid = r_main_valid;
    assign o_out_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_valid || w_take) begin
                r_main_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_take) begin
            r_main_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (!r_main_valid || w_take) begin
                r_main <= i_result;
            end else begin
                r_skid <= i_result;
            end
        end
    end

    `MHA_ASSERT_NOW(a_skid_needs_main, i_clk, i_rst_n, r_skid_valid, r_main_valid)
    `MHA_ASSERT_NEXT(a_stalled_main_holds, i_clk, i_rst_n, r_main_valid && i_out_stall, r_main_valid)
    `MHA_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, r_skid_valid && !i_out_stall, !r_skid_valid)
    `MHA_ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, i_push && !r_skid_valid, r_main_valid)

endmodule

// File: test/tb.sv
// Self-checking testbench for multiclass_hysteresis_alarm: directed and random requests
// against a cycle-free predictor of the per-class hit counts and active flags.
// Depends on mha_pkg and the block's RTL only.
module tb;
    import mha_pkg::*;

    localparam int unsigned CLASS_COUNT = 4;
    localparam int unsigned HIT_CAP     = 1000;
    localparam int unsigned PROB_MAX    = (1 << PROB_W) - 1;
    localparam int unsigned QUIET_LIMIT = 4000;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    multiclass_hysteresis_alarm #(
        .NUM_CLASSES(CLASS_COUNT),
        .COUNT_CAP  (HIT_CAP)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the configuration and of the class state.
    logic [CFG_DATA_W-1:0] thr_shadow [CLASS_COUNT];
    logic [NEED_W-1:0]     need_shadow;
    logic [MASK_W-1:0]     mask_shadow;
    logic [NEED_W-1:0]     class_hits [CLASS_COUNT];
    logic [MASK_W-1:0]     active_bits;

    t_in_item    request_backlog [$];
    t_out_item   alarm_expected [$];
    int unsigned requests_queued = 0;
    int unsigned requests_taken  = 0;
    int unsigned results_seen    = 0;
    int unsigned mismatch_count  = 0;
    int unsigned send_wait       = 0;
    int unsigned send_calm       = 0;
    int unsigned stall_left      = 0;
    int unsigned recv_calm       = 0;
    int unsigned quiet_cycles    = 0;
    t_out_item   want;

    function automatic t_out_item alarm_response(input t_in_item req);
        t_out_item         res;
        int unsigned       c;
        logic [PROB_W-1:0] on_level;
        logic [PROB_W-1:0] off_level;
        res = '0;
        if (req.opcode == OP_CLEAR) begin
            for (c = 0; c < CLASS_COUNT; c++) class_hits[c] = '0;
            active_bits = '0;
        end else if (req.class_index < CLASS_COUNT) begin
            c = 32'(req.class_index);
            on_level  = thr_shadow[c][31:16];
            off_level = thr_shadow[c][15:0];
            if (req.probability > on_level) begin
                if (class_hits[c] < HIT_CAP) class_hits[c] = class_hits[c] + 1'b1;
                if (class_hits[c] >= need_shadow) active_bits[c] = 1'b1;
            end else if (req.probability < off_level) begin
                class_hits[c]  = '0;
                active_bits[c] = 1'b0;
            end
            res.class_active = active_bits[c];
            res.class_count  = class_hits[c];
        end
        res.active_mask = active_bits;
        res.any_alert   = |(active_bits & ~mask_shadow);
        return res;
    endfunction

    function automatic int unsigned next_pause(inout int unsigned calm_left);
        int unsigned roll;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(20, 60);
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        else if (roll < 85) return $urandom_range(1, 3);
        else if (roll < 97) return $urandom_range(4, 12);
        else return $urandom_range(20, 60);
    endfunction

    function automatic logic [PROB_W-1:0] pick_probability(input int unsigned cls);
        int unsigned on_level;
        int unsigned off_level;
        int unsigned lo;
        int unsigned hi;
        int unsigned roll;
        on_level  = 32'(thr_shadow[cls][31:16]);
        off_level = 32'(thr_shadow[cls][15:0]);
        lo = (on_level < off_level) ? on_level : off_level;
        hi = (on_level < off_level) ? off_level : on_level;
        roll = $urandom_range(0, 11);
        if (roll < 5) return (on_level < PROB_MAX)
                             ? PROB_W'($urandom_range(on_level + 1, PROB_MAX))
                             : PROB_W'(PROB_MAX);
        if (roll < 7) return (off_level > 0) ? PROB_W'($urandom_range(0, off_level - 1))
                                             : '0;
        if (roll < 9) return PROB_W'($urandom_range(lo, hi));
        if (roll == 9) return PROB_W'($urandom_range(0, PROB_MAX));
        case ($urandom_range(0, 5))
            0: return '0;
            1: return PROB_W'(PROB_MAX);
            2: return PROB_W'(on_level);
            3: return PROB_W'(off_level);
            4: return (on_level < PROB_MAX) ? PROB_W'(on_level + 1) : PROB_W'(on_level);
            default: return (off_level > 0) ? PROB_W'(off_level - 1) : PROB_W'(off_level);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_thresholds();
        logic [PROB_W-1:0] a;
        logic [PROB_W-1:0] b;
        a = PROB_W'($urandom_range(0, PROB_MAX));
        b = PROB_W'($urandom_range(0, PROB_MAX));
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: return (a < b) ? {a, b} : {b, a};
            2: return {a, a};
            default: return (a < b) ? {b, a} : {a, b};
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        mismatch_count++;
        $display("result %0d: %s is %0h, expected %0h", results_seen, what, got, exp_val);
    endtask

    task automatic queue_request(input logic op, input logic [1:0] cls,
                                 input logic [PROB_W-1:0] prob);
        t_in_item req;
        req.opcode      = op;
        req.class_index = cls;
        req.probability = prob;
        request_backlog.push_back(req);
        requests_queued++;
    endtask

    task automatic queue_clear();
        queue_request(OP_CLEAR, 2'($urandom_range(0, 3)), PROB_W'($urandom_range(0, PROB_MAX)));
    endtask

    task automatic wait_drained();
        while (requests_taken != requests_queued || alarm_expected.size() != 0)
            @(posedge i_clk);
    endtask

    // The valid line stays high across back-to-back writes and is lowered by release_cfg.
    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_THR0, REG_THR1, REG_THR2, REG_THR3: thr_shadow[idx[1:0]] = data;
            REG_NEED: need_shadow = data[NEED_W-1:0];
            REG_MASK: mask_shadow = data[MASK_W-1:0];
            default: ;
        endcase
    endtask

    task automatic release_cfg();
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] need_word(input logic [NEED_W-1:0] need);
        logic [CFG_DATA_W-1:0] word;
        word = $urandom();
        word[NEED_W-1:0] = need;
        return word;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_wait = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                alarm_expected.push_back(alarm_response(i_in_data));
                requests_taken++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_wait > 0) begin
                    send_wait--;
                    i_in_valid <= 1'b0;
                end else if (request_backlog.size() > 0) begin
                    i_in_data  <= request_backlog.pop_front();
                    i_in_valid <= 1'b1;
                    send_wait = next_pause(send_calm);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (alarm_expected.size() == 0) begin
                    report_mismatch("unexpected result", 32'(o_out_data), '0);
                end else begin
                    want = alarm_expected.pop_front();
                    if (o_out_data.class_active !== want.class_active)
                        report_mismatch("class_active", 32'(o_out_data.class_active),
                                        32'(want.class_active));
                    if (o_out_data.class_count !== want.class_count)
                        report_mismatch("class_count", 32'(o_out_data.class_count),
                                        32'(want.class_count));
                    if (o_out_data.active_mask !== want.active_mask)
                        report_mismatch("active_mask", 32'(o_out_data.active_mask),
                                        32'(want.active_mask));
                    if (o_out_data.any_alert !== want.any_alert)
                        report_mismatch("any_alert", 32'(o_out_data.any_alert),
                                        32'(want.any_alert));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                stall_left = next_pause(recv_calm);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        int unsigned i;
        int unsigned phase;
        int unsigned sent;
        int unsigned run_len;
        int unsigned sat_hits;
        int unsigned cls;
        logic [PROB_W-1:0] prob;
        logic [NEED_W-1:0] need;

        for (i = 0; i < CLASS_COUNT; i++) begin
            thr_shadow[i] = THR_RESET;
            class_hits[i] = '0;
        end
        need_shadow = NEED_RESET;
        mask_shadow = MASK_RESET;
        active_bits = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default thresholds: exact on and off levels sit in the band, one below off clears.
        repeat (3) queue_request(OP_SAMPLE, 2'd0, 16'hB334);
        queue_request(OP_SAMPLE, 2'd0, 16'hB333);
        queue_request(OP_SAMPLE, 2'd0, 16'h8000);
        queue_request(OP_SAMPLE, 2'd0, 16'h7FFF);
        repeat (2) queue_request(OP_SAMPLE, 2'd1, 16'hFFFF);
        queue_request(OP_SAMPLE, 2'd1, 16'h0000);
        repeat (3) queue_request(OP_SAMPLE, 2'd2, 16'hFFFF);
        repeat (3) queue_request(OP_SAMPLE, 2'd3, 16'hB334);
        queue_request(OP_CLEAR, 2'd3, 16'hFFFF);
        queue_request(OP_SAMPLE, 2'd3, 16'h0000);
        wait_drained();

        // Crossed and extreme thresholds, a need count of zero and a partial alert mask.
        set_register(REG_THR0, 32'h4000_C000);
        set_register(REG_THR1, 32'hFFFF_0000);
        set_register(REG_THR2, 32'h0000_FFFF);
        set_register(REG_THR3, 32'h0000_0000);
        set_register(REG_NEED, need_word(10'd0));
        set_register(REG_MASK, 32'hFFFF_FFFA);
        set_register(REG_SPARE_LO, $urandom());
        set_register(REG_SPARE_HI, $urandom());
        release_cfg();
        queue_request(OP_SAMPLE, 2'd0, 16'h8000);
        queue_request(OP_SAMPLE, 2'd0, 16'h2000);
        queue_request(OP_SAMPLE, 2'd0, 16'hE000);
        queue_request(OP_SAMPLE, 2'd1, 16'hFFFF);
        queue_request(OP_SAMPLE, 2'd1, 16'h0000);
        queue_request(OP_SAMPLE, 2'd2, 16'h0000);
        queue_request(OP_SAMPLE, 2'd2, 16'h0001);
        queue_request(OP_SAMPLE, 2'd3, 16'h0000);
        queue_request(OP_SAMPLE, 2'd3, 16'hFFFF);
        wait_drained();

        // Drive class 0 past the count ceiling with the need count at the ceiling.
        set_register(REG_THR0, 32'h0000_0000);
        set_register(REG_THR1, random_thresholds());
        set_register(REG_THR2, random_thresholds());
        set_register(REG_THR3, 32'hFFFF_FFFF);
        set_register(REG_NEED, need_word(NEED_W'(HIT_CAP)));
        set_register(REG_MASK, $urandom());
        release_cfg();
        queue_clear();
        sat_hits = 0;
        while (sat_hits < HIT_CAP + 3) begin
            if ($urandom_range(0, 31) == 0) begin
                cls = $urandom_range(1, CLASS_COUNT - 1);
                queue_request(OP_SAMPLE, 2'(cls), pick_probability(cls));
            end else begin
                prob = PROB_W'($urandom_range(0, PROB_MAX));
                queue_request(OP_SAMPLE, 2'd0, prob);
                if (prob != 0) sat_hits++;
            end
        end
        wait_drained();

        // A need count above the ceiling leaves an already active class active.
        set_register(REG_NEED, need_word(10'h3FF));
        set_register(REG_MASK, 32'h0000_0000);
        release_cfg();
        repeat (3) queue_request(OP_SAMPLE, 2'd0, 16'hFFFF);
        queue_request(OP_SAMPLE, 2'd0, 16'h0000);
        wait_drained();

        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0: need = '0;
                2: need = NEED_W'($urandom_range(HIT_CAP + 1, (1 << NEED_W) - 1));
                default: need = ($urandom_range(0, 3) == 0) ? NEED_W'(HIT_CAP)
                                                            : NEED_W'($urandom_range(1, 5));
            endcase
            set_register(REG_THR0, random_thresholds());
            set_register(REG_THR1, random_thresholds());
            set_register(REG_THR2, random_thresholds());
            set_register(REG_THR3, random_thresholds());
            set_register(REG_NEED, need_word(need));
            set_register(REG_MASK, (phase == 1) ? 32'hFFFF_FFFF : $urandom());
            if ($urandom_range(0, 1) == 0) set_register(REG_SPARE_HI, $urandom());
            release_cfg();
            sent = 0;
            while (sent < 16) begin
                if ($urandom_range(0, 24) == 0) begin
                    queue_clear();
                    sent++;
                end else begin
                    cls = $urandom_range(0, CLASS_COUNT - 1);
                    run_len = $urandom_range(1, 6);
                    for (i = 0; i < run_len; i++) begin
                        queue_request(OP_SAMPLE, 2'(cls), pick_probability(cls));
                        sent++;
                    end
                end
            end
            wait_drained();
        end

        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/mha_pkg.sv
hw/rtl/mha_cfg_regs.sv
hw/rtl/mha_class_update.sv
hw/rtl/mha_out_skid.sv
hw/rtl/multiclass_hysteresis_alarm.sv
test/tb.sv
